// File: src/tristate_remote_switch_encoder_assert.svh
// Assertion macros shared by the tristate remote switch encoder modules.
`ifndef TRISTATE_REMOTE_SWITCH_ENCODER_ASSERT_SVH
`define TRISTATE_REMOTE_SWITCH_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rse_pkg.sv
// Package with word types and constants of the tristate remote switch encoder.
package rse_pkg;

  localparam int WORD_SYMBOLS_DEF = 12;
  localparam int SYM_W = 4;

  localparam logic [15:0] UNIT_TICKS_RESET = 16'd350;

  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [4:0] UNITS_SHORT    = 5'd1;
  localparam logic [4:0] UNITS_LONG     = 5'd3;
  localparam logic [4:0] UNITS_SYNC_LOW = 5'd31;

  localparam logic [SYM_W-1:0] CHAN_BASE = SYM_W'(4);

  typedef struct packed {
    logic       action;
    logic [7:0] address;
    logic [7:0] channel;
    logic       switch_on;
    logic [7:0] repeat_count;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
  } res_t;

endpackage

// File: src/rse_core.sv
// Pulse sequencer: transmission state, timing counters and per-word result.
module rse_core #(
  parameter int WORD_SYMBOLS = rse_pkg::WORD_SYMBOLS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           accept,
  input  rse_pkg::cmd_t  cmd,
  output rse_pkg::res_t  res
);

  localparam int SW = rse_pkg::SYM_W;
  localparam logic [SW-1:0] WORD_LEN = SW'(WORD_SYMBOLS);
  localparam logic [SW-1:0] LAST_POS = SW'(WORD_SYMBOLS - 1);

  logic [15:0]   unit_ticks;
  logic [7:0]    repeats_left, repeats_left_next;
  logic [SW-1:0] symbol_pos, symbol_pos_next;
  logic          second_bit, second_bit_next;
  logic          in_low_phase, in_low_phase_next;
  logic [4:0]    units_done, units_done_next;
  logic [15:0]   tick_count, tick_count_next;
  logic [1:0]    addr_pos, addr_pos_next;
  logic [1:0]    chan_pos, chan_pos_next;
  logic          on_flag, on_flag_next;
  logic          active, active_next;

  logic          sym_zero;
  logic          is_sync;
  logic          long_bit;
  logic [4:0]    phase_len;
  logic [15:0]   limit;
  logic [15:0]   tick_inc;
  logic [4:0]    units_inc;

  // Decode of the symbol under the cursor and the length of the current phase.
  assign sym_zero = (symbol_pos == {{(SW-2){1'b0}}, addr_pos}) ||
                    (symbol_pos == rse_pkg::CHAN_BASE + {{(SW-2){1'b0}}, chan_pos}) ||
                    ((symbol_pos == LAST_POS) && !on_flag);
  assign is_sync  = (symbol_pos >= WORD_LEN);
  assign long_bit = !is_sync && second_bit && !sym_zero;

  always_comb begin
    if (!in_low_phase) begin
      phase_len = long_bit ? rse_pkg::UNITS_LONG : rse_pkg::UNITS_SHORT;
    end else if (is_sync) begin
      phase_len = rse_pkg::UNITS_SYNC_LOW;
    end else begin
      phase_len = long_bit ? rse_pkg::UNITS_SHORT : rse_pkg::UNITS_LONG;
    end
  end

  // A unit length of zero behaves as one tick.
  assign limit     = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
  assign tick_inc  = tick_count + 16'd1;
  assign units_inc = units_done + 5'd1;

  always_comb begin
    repeats_left_next = repeats_left;
    symbol_pos_next   = symbol_pos;
    second_bit_next   = second_bit;
    in_low_phase_next = in_low_phase;
    units_done_next   = units_done;
    tick_count_next   = tick_count;
    addr_pos_next     = addr_pos;
    chan_pos_next     = chan_pos;
    on_flag_next      = on_flag;
    active_next       = active;

    if (cmd.action == rse_pkg::ACT_COMMAND) begin
      if (!active) begin
        addr_pos_next = cmd.address[1:0] - 2'd1;
        chan_pos_next = cmd.channel[1:0] - 2'd1;
        on_flag_next  = cmd.switch_on;
        if (cmd.repeat_count != 8'd0) begin
          repeats_left_next = cmd.repeat_count;
          symbol_pos_next   = '0;
          second_bit_next   = 1'b0;
          in_low_phase_next = 1'b0;
          units_done_next   = '0;
          tick_count_next   = '0;
          active_next       = 1'b1;
        end
      end
    end else if (active) begin
      if (tick_inc < limit) begin
        tick_count_next = tick_inc;
      end else begin
        tick_count_next = '0;
        if (units_inc < phase_len) begin
          units_done_next = units_inc;
        end else begin
          units_done_next = '0;
          if (!in_low_phase) begin
            in_low_phase_next = 1'b1;
          end else begin
            in_low_phase_next = 1'b0;
            if (is_sync) begin
              symbol_pos_next   = '0;
              second_bit_next   = 1'b0;
              repeats_left_next = repeats_left - 8'd1;
              if (repeats_left == 8'd1) begin
                active_next = 1'b0;
              end
            end else if (!second_bit) begin
              second_bit_next = 1'b1;
            end else begin
              second_bit_next = 1'b0;
              symbol_pos_next = symbol_pos + SW'(1);
            end
          end
        end
      end
    end
  end

  // A command reports the level it leaves behind; a tick reports the level it drives.
  always_comb begin
    if (cmd.action == rse_pkg::ACT_COMMAND) begin
      res.line_level = active_next && !in_low_phase_next;
      res.busy_res   = active_next;
    end else begin
      res.line_level = active && !in_low_phase;
      res.busy_res   = active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks   <= rse_pkg::UNIT_TICKS_RESET;
      repeats_left <= '0;
      symbol_pos   <= '0;
      second_bit   <= 1'b0;
      in_low_phase <= 1'b0;
      units_done   <= '0;
      tick_count   <= '0;
      addr_pos     <= '0;
      chan_pos     <= '0;
      on_flag      <= 1'b0;
      active       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_ticks <= cfg_data;
      end
      if (accept) begin
        repeats_left <= repeats_left_next;
        symbol_pos   <= symbol_pos_next;
        second_bit   <= second_bit_next;
        in_low_phase <= in_low_phase_next;
        units_done   <= units_done_next;
        tick_count   <= tick_count_next;
        addr_pos     <= addr_pos_next;
        chan_pos     <= chan_pos_next;
        on_flag      <= on_flag_next;
        active       <= active_next;
      end
    end
  end

`include "tristate_remote_switch_encoder_assert.svh"

  `RSE_ASSERT_NOW(a_idle_clean, !active, (!in_low_phase && symbol_pos == '0 && units_done == '0 && tick_count == '0), "idle sequencer left with stale timing state")
  `RSE_ASSERT_NOW(a_pos_range, active, (symbol_pos <= WORD_LEN), "symbol cursor past the sync slot")
  `RSE_ASSERT_NOW(a_repeats_live, active, (repeats_left != 8'd0), "active with no repeats left")

endmodule

// File: src/rse_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module rse_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rse_pkg::res_t push_word,
  output logic          can_push,
  output logic          res_valid,
  input  logic          res_ready,
  output rse_pkg::res_t res_word
);

  rse_pkg::res_t out_q;
  rse_pkg::res_t skid_q;
  logic          out_vld;
  logic          skid_vld;
  logic          pop;

  assign pop       = out_vld && res_ready;
  assign can_push  = !skid_vld;
  assign res_valid = out_vld;
  assign res_word  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (pop) begin
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (out_vld && !pop) begin
        skid_vld <= 1'b1;
      end else begin
        out_vld <= 1'b1;
      end
    end else if (pop) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld && !pop) begin
        skid_q <= push_word;
      end else begin
        out_q <= push_word;
      end
    end
  end

`include "tristate_remote_switch_encoder_assert.svh"

  `RSE_ASSERT_NOW(a_skid_behind_out, skid_vld, out_vld, "skid entry held without an output entry")
  `RSE_ASSERT_NEXT(a_skid_promotes, (skid_vld && res_ready), (out_vld && !skid_vld), "skid entry not moved into the output register")

endmodule

// File: src/tristate_remote_switch_encoder.sv
// Top level of the tristate remote switch encoder.
//
// Usage: each word on the cmd channel is either a command (action 0) carrying
// address, channel, on/off and a repeat count, or a tick (action 1) that moves
// time forward by one tick. Every accepted word yields exactly one word on the
// res channel with the line level and a busy flag. A command while a
// transmission runs is ignored; a repeat count of zero sends nothing.
// The unit length in ticks is written through cfg_we/cfg_data while idle; the
// user must keep to it; the block does not enforce it. Results are registered
// before res offers them. Throughput is one word per cycle while cmd_ready is
// high, set by the single pass of the sequencer's counter and compare logic.
// A two-entry output buffer lets the block take one more word while a result
// waits; when both entries are full, cmd_ready drops until res drains.
// Synchronous reset returns the line to idle (low, not busy), empties the
// buffer and restores the unit length to 350 ticks.
module tristate_remote_switch_encoder #(
  parameter int WORD_SYMBOLS = rse_pkg::WORD_SYMBOLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  rse_pkg::cmd_t cmd_word,
  output logic          res_valid,
  input  logic          res_ready,
  output rse_pkg::res_t res_word,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data
);

  logic          accept;
  rse_pkg::res_t core_res;

  // A word is taken whenever the result buffer has a free entry.
  assign accept = cmd_valid && cmd_ready;

  rse_core #(
    .WORD_SYMBOLS(WORD_SYMBOLS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .cmd      (cmd_word),
    .res      (core_res)
  );

  // The result buffer separates the sequencer from a stalling receiver.
  rse_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (core_res),
    .can_push  (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the tristate remote switch encoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Code word length of the block as instantiated (default parameter).
  localparam int CODE_LEN = rse_pkg::WORD_SYMBOLS_DEF;
  // Units in one pass of code word plus sync: every symbol is two bits of
  // four units each, and the sync is one unit high and 31 low.
  localparam int FRAME_UNITS = 2 * CODE_LEN * (rse_pkg::UNITS_SHORT + rse_pkg::UNITS_LONG)
                               + rse_pkg::UNITS_SHORT + rse_pkg::UNITS_SYNC_LOW;
  localparam int RANDOM_WORDS = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 10;
  localparam int LONG_STALL = 150;
  localparam int QUIET_LIMIT = 2000;

  // One word waiting to be offered, with the idle cycles that come first.
  typedef struct {
    rse_pkg::cmd_t word;
    int            gap;
  } outgoing_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  rse_pkg::cmd_t cmd_word = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  rse_pkg::res_t res_word;
  logic          cfg_we = 1'b0;
  logic [15:0]   cfg_data = '0;

  tristate_remote_switch_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Encoder state as the testbench predicts it. It starts at its reset
  // value and only changes when a word is accepted or the unit length is
  // written.
  // ---------------------------------------------------------------------
  logic [15:0] unit_cfg = rse_pkg::UNIT_TICKS_RESET;
  logic [7:0]  reps_left = '0;
  logic [3:0]  sym_idx = '0;
  logic        odd_bit = 1'b0;
  logic        low_half = 1'b0;
  logic [4:0]  unit_cnt = '0;
  logic [15:0] tick_cnt = '0;
  logic [1:0]  addr_slot = '0;
  logic [1:0]  chan_slot = '0;
  logic        on_cmd = 1'b0;
  logic        sending = 1'b0;

  // Stimulus still to be offered, and line words expected back in order.
  outgoing_t     outgoing_words[$];
  rse_pkg::res_t awaited_levels[$];
  int            words_issued = 0;
  int            words_accepted = 0;
  int            error_count = 0;

  // Handshake results seen at the last rising edge, used by the drivers
  // at the following falling edge.
  logic        cmd_fire = 1'b0;
  logic        res_fire = 1'b0;

  // Traffic shaping, set by the stimulus process at a rising edge.
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  int          stall_req = 0;

  // A symbol is '0' at the address slot, at the channel slot, and in the
  // last position when the command switches off; otherwise it is 'F'.
  function automatic logic sym_is_zero();
    if (int'(sym_idx) == int'(addr_slot)) return 1'b1;
    if (int'(sym_idx) == int'(rse_pkg::CHAN_BASE) + int'(chan_slot)) return 1'b1;
    if (int'(sym_idx) == CODE_LEN - 1 && !on_cmd) return 1'b1;
    return 1'b0;
  endfunction

  // Length in units of the high or low half of the current bit or sync.
  // Only the second bit of an 'F' symbol is a long bit.
  function automatic int half_units();
    logic at_sync;
    logic long_bit;
    at_sync = int'(sym_idx) >= CODE_LEN;
    long_bit = !at_sync && odd_bit && !sym_is_zero();
    if (!low_half) return long_bit ? rse_pkg::UNITS_LONG : rse_pkg::UNITS_SHORT;
    if (at_sync) return rse_pkg::UNITS_SYNC_LOW;
    return long_bit ? rse_pkg::UNITS_SHORT : rse_pkg::UNITS_LONG;
  endfunction

  // One tick of time: count ticks into units, units into halves, and walk
  // through bit, symbol, sync and repeat. The last sync ends the burst.
  function automatic void advance_tick();
    int unit_len;
    unit_len = (unit_cfg == 16'd0) ? 1 : int'(unit_cfg);
    tick_cnt = tick_cnt + 16'd1;
    if (int'(tick_cnt) < unit_len) return;
    tick_cnt = '0;
    unit_cnt = unit_cnt + 5'd1;
    if (int'(unit_cnt) < half_units()) return;
    unit_cnt = '0;
    if (!low_half) begin
      low_half = 1'b1;
      return;
    end
    low_half = 1'b0;
    if (int'(sym_idx) >= CODE_LEN) begin
      sym_idx = '0;
      odd_bit = 1'b0;
      reps_left = reps_left - 8'd1;
      if (reps_left == 8'd0) sending = 1'b0;
    end else if (!odd_bit) begin
      odd_bit = 1'b1;
    end else begin
      odd_bit = 1'b0;
      sym_idx = sym_idx + 4'd1;
    end
  endfunction

  // Line word for one accepted input word. A command reports the level
  // after it is taken; a tick reports the level driven during that tick and
  // then moves time on.
  function automatic rse_pkg::res_t next_line_word(input rse_pkg::cmd_t w);
    rse_pkg::res_t r;
    logic [7:0]    adj;
    if (w.action == rse_pkg::ACT_COMMAND) begin
      if (!sending) begin
        adj = w.address - 8'd1;
        addr_slot = adj[1:0];
        adj = w.channel - 8'd1;
        chan_slot = adj[1:0];
        on_cmd = w.switch_on;
        if (w.repeat_count != 8'd0) begin
          reps_left = w.repeat_count;
          sym_idx = '0;
          odd_bit = 1'b0;
          low_half = 1'b0;
          unit_cnt = '0;
          tick_cnt = '0;
          sending = 1'b1;
        end
      end
      r.line_level = sending && !low_half;
      r.busy_res = sending;
    end else begin
      r.line_level = sending && !low_half;
      r.busy_res = sending;
      if (sending) advance_tick();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: at every rising edge it predicts the line word for an
  // accepted input word and checks an accepted output word against the
  // oldest prediction. The input side is handled first, although a result is
  // registered, so a word never comes back at the edge it went in.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    rse_pkg::res_t want;
    if (rst) begin
      cmd_fire = 1'b0;
      res_fire = 1'b0;
    end else begin
      cmd_fire = cmd_valid && cmd_ready;
      res_fire = res_valid && res_ready;
      if (cmd_fire) begin
        awaited_levels.push_back(next_line_word(cmd_word));
        words_accepted++;
      end
      if (res_fire) begin
        if (awaited_levels.size() == 0) begin
          $error("unexpected word on res: line_level %0b busy_res %0b",
                 res_word.line_level, res_word.busy_res);
          error_count++;
        end else begin
          want = awaited_levels.pop_front();
          if (res_word.line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b",
                   want.line_level, res_word.line_level);
            error_count++;
          end
          if (res_word.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b",
                   want.busy_res, res_word.busy_res);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: offers the queued words at falling edges. A word stays valid
  // and unchanged until the edge that accepts it; the idle gap drawn for
  // the next word is spent with valid low.
  // ---------------------------------------------------------------------
  outgoing_t cur_word;
  logic      word_staged = 1'b0;
  int        gap_left = 0;

  always @(negedge clk) begin : driver
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_fire) begin
      if (!word_staged && outgoing_words.size() != 0) begin
        cur_word = outgoing_words.pop_front();
        word_staged = 1'b1;
        gap_left = cur_word.gap;
      end
      if (word_staged && gap_left == 0) begin
        cmd_word <= cur_word.word;
        cmd_valid <= 1'b1;
        word_staged = 1'b0;
      end else begin
        cmd_valid <= 1'b0;
        if (word_staged) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: draws a random stall after every word it takes
  // while idling is enabled. A long stall request holds ready low for that
  // many cycles, counted here, so that the two-entry buffer fills and the
  // block has to push back on its input.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  int rx_gap = 0;

  always @(negedge clk) begin : receiver
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (stall_req > 0) begin
        stall_left = stall_req;
        stall_req = 0;
      end
      if (res_fire) rx_gap = rx_idle_en ? $urandom_range(0, 7) : 0;
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run in which no word moves on either channel for too long
  // has hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic rse_pkg::cmd_t command_word(input logic [7:0] a, input logic [7:0] c,
                                                 input logic on, input logic [7:0] rc);
    rse_pkg::cmd_t w;
    w.action = rse_pkg::ACT_COMMAND;
    w.address = a;
    w.channel = c;
    w.switch_on = on;
    w.repeat_count = rc;
    return w;
  endfunction

  // Word with random content in every field; the fields an action does not
  // use should make no difference.
  function automatic rse_pkg::cmd_t random_word(input logic act);
    logic [31:0]   r;
    rse_pkg::cmd_t w;
    r = $urandom;
    w = r[$bits(rse_pkg::cmd_t)-1:0];
    w.action = act;
    return w;
  endfunction

  task automatic queue_word(input rse_pkg::cmd_t w);
    outgoing_t o;
    o.word = w;
    o.gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    outgoing_words.push_back(o);
    words_issued++;
  endtask

  // Waits at falling edges until everything sent has come back, then lets
  // the block settle before anything is reconfigured.
  task automatic drain();
    @(negedge clk);
    while (words_accepted != words_issued || awaited_levels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the unit length once no word is in flight.
  task automatic set_unit_len(input logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    unit_cfg = v;
  endtask

  // Opens a stretch of traffic at a rising edge with the given idling.
  task automatic begin_traffic(input logic tx_idle, input logic rx_idle, input int stall);
    @(posedge clk);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    stall_req = stall;
  endtask

  // A command followed by exactly the ticks that its burst lasts plus extra
  // idle ones. Commands sprinkled into the burst arrive while the block is
  // busy and must be ignored.
  task automatic send_frame(input logic [7:0] a, input logic [7:0] c, input logic on,
                            input logic [7:0] rc, input int extra, input int noise_pct);
    int total;
    total = int'(rc) * FRAME_UNITS * ((unit_cfg == 16'd0) ? 1 : int'(unit_cfg));
    queue_word(command_word(a, c, on, rc));
    for (int k = 0; k < total + extra; k++) begin
      if (k < total && noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
        queue_word(random_word(rse_pkg::ACT_COMMAND));
      queue_word(random_word(rse_pkg::ACT_TICK));
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int idles;
    logic [15:0] len;
    logic [7:0] rc;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // At the reset unit length: a zero repeat count sends nothing and
    // ticks while idle change nothing; then a burst with address and
    // channel zero, switching off, runs part of its first unit. The unit
    // is then shortened in the middle of the burst and the burst is run
    // out to its end.
    begin_traffic(1'b0, 1'b0, 0);
    queue_word(command_word(8'hFF, 8'hFF, 1'b1, 8'd0));
    queue_word(random_word(rse_pkg::ACT_TICK));
    queue_word(random_word(rse_pkg::ACT_TICK));
    queue_word(command_word(8'h00, 8'h00, 1'b0, 8'd1));
    for (int k = 0; k < 40; k++) queue_word(random_word(rse_pkg::ACT_TICK));
    set_unit_len(16'd1);
    for (int k = 0; k < FRAME_UNITS + 12; k++) queue_word(random_word(rse_pkg::ACT_TICK));

    // Shortest unit: two repeats, ignored commands, and a long receiver
    // stall at the start while the sender keeps going.
    set_unit_len(16'd1);
    begin_traffic(1'b1, 1'b1, LONG_STALL);
    send_frame(8'hFF, 8'hFF, 1'b1, 8'd2, 2, 5);
    queue_word(command_word(8'h01, 8'h01, 1'b0, 8'd0));

    // A unit length of zero acts as one.
    set_unit_len(16'd0);
    begin_traffic(1'b0, 1'b0, 0);
    send_frame(8'h01, 8'h04, 1'b0, 8'd1, 3, 1);

    // Random part: whole bursts with random content at short unit lengths,
    // between them zero-count commands and stray ticks.
    base = words_issued;
    while (words_issued - base < RANDOM_WORDS) begin
      case ($urandom_range(0, 5))
        0: len = 16'd0;
        4: len = 16'd2;
        5: len = 16'd3;
        default: len = 16'd1;
      endcase
      set_unit_len(len);
      begin_traffic(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? LONG_STALL : 0);
      idles = $urandom_range(0, 4);
      for (int j = 0; j < idles; j++) begin
        if ($urandom_range(0, 1) == 1) begin
          queue_word(random_word(rse_pkg::ACT_TICK));
        end else begin
          queue_word(command_word(8'($urandom), 8'($urandom), 1'($urandom), 8'd0));
        end
      end
      rc = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 3)) : 8'd1;
      send_frame(8'($urandom), 8'($urandom), 1'($urandom), rc, $urandom_range(0, 3), 3);
    end

    // Longest unit: a burst that stays in its first high unit, with a
    // command that arrives while busy. The burst is left running at the end.
    set_unit_len(16'hFFFF);
    begin_traffic(1'b0, 1'b0, 0);
    queue_word(command_word(8'h07, 8'h09, 1'b1, 8'd1));
    for (int k = 0; k < 20; k++) begin
      if (k == 10) queue_word(random_word(rse_pkg::ACT_COMMAND));
      queue_word(random_word(rse_pkg::ACT_TICK));
    end

    // Wait for the last results, then a tail for anything stray.
    @(negedge clk);
    while (words_accepted != words_issued || awaited_levels.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: tristate_remote_switch_encoder.f
+incdir+src
src/rse_pkg.sv
src/rse_core.sv
src/rse_out_buf.sv
src/tristate_remote_switch_encoder.sv
tb/sv/testbench.sv
